[hw/rtl/deque_with_remove_by_value_assert.svh]
// Assertion macros shared by the deque RTL
`ifndef DEQUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH
`define DEQUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define DQRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define DQRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dqrm_pkg.sv]
// Command and status codes and field widths of the deque
`default_nettype none

package dqrm_pkg;

    localparam int CMD_W = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_REM = 2'd2,
        CMD_POP = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

endpackage

`default_nettype wire

[hw/rtl/dqrm_ram.sv]
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module dqrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/deque_with_remove_by_value.sv]
// Deque: a bounded ordered store of signed 32-bit words, with remove by value.
// The entries live in one RAM as a circular buffer (head pointer and count).
// Enqueue and any refused or empty command finish in the idle state; dequeue and
// pop go through a read state for the RAM read. Remove reads the RAM one entry
// a cycle from the head until it finds a match, then moves each later entry down
// by one, a read and a write per cycle; the single RAM read port sets this pace.
// The result word is loaded into the output register when the command ends and
// that register is free. Input is stalled while a command is in progress and
// while a finished result waits behind a stalled output register.
`default_nettype none

`include "deque_with_remove_by_value_assert.svh"

module deque_with_remove_by_value #(
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [dqrm_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic signed [dqrm_pkg::VAL_W-1:0]  i_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [dqrm_pkg::VAL_W-1:0]       o_result_value,
    output logic      [dqrm_pkg::ST_W-1:0]          o_status,
    output logic      [dqrm_pkg::CNT_W-1:0]         o_entry_count
);

    import dqrm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    // RAM address of logical position off from the head.
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] head,
                                                 input logic [CW:0]   off);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(off);
        if (s >= DEPTH_SUM) s = s - DEPTH_SUM;
        if (s >= DEPTH_SUM) s = s - DEPTH_SUM;
        return s[AW-1:0];
    endfunction

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_pos, n_pos;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic signed [VAL_W-1:0] r_res_val, n_res_val;
    t_status                r_res_st, n_res_st;
    logic                   r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_val, n_out_val;
    t_status                r_out_st, n_out_st;
    logic [CNT_W-1:0]       r_out_cnt, n_out_cnt;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VAL_W-1:0]       ram_wdata, ram_rdata;

    logic                   fin, out_free, out_load;
    logic [CW:0]            pos_p1, pos_p2, count_x;
    logic [CW+CNT_W-1:0]    count_ext;

    dqrm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_val;
    assign o_status       = r_out_st;
    assign o_entry_count  = r_out_cnt;

    assign out_free = !r_out_valid || !i_stall;
    assign pos_p1   = {1'b0, r_pos} + 1'b1;
    assign pos_p2   = {1'b0, r_pos} + 2'd2;
    assign count_x  = {1'b0, r_count};

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_val     = r_val;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        fin       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = wrap_addr(r_head, {1'b0, r_pos});
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = wrap_addr(r_head, pos_p1);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val    = i_value;
                    n_res_st = ST_OK;
                    unique case (t_cmd'(i_cmd))
                        CMD_ENQ: begin
                            n_res_val = i_value;
                            fin       = 1'b1;
                            if (r_count == DEPTH_CNT) begin
                                n_res_st = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = wrap_addr(r_head, count_x);
                                ram_wdata = i_value;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_DEQ: begin
                            if (r_count == '0) begin
                                n_res_val = '0;
                                n_res_st  = ST_EMPTY;
                                fin       = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_head    = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                                n_count   = r_count - 1'b1;
                                n_state   = S_READ;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_res_val = '0;
                                n_res_st  = ST_EMPTY;
                                fin       = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = wrap_addr(r_head, {1'b0, r_count - 1'b1});
                                n_count   = r_count - 1'b1;
                                n_state   = S_READ;
                            end
                        end
                        CMD_REM: begin
                            n_res_val = i_value;
                            if (r_count == '0) begin
                                n_res_st = ST_NOTFOUND;
                                fin      = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_pos     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_val = $signed(ram_rdata);
                fin       = 1'b1;
            end
            S_SCAN: begin
                // read data is the entry at r_pos; fetch the next one meanwhile
                ram_re = (pos_p1 < count_x);
                if (ram_rdata == r_val) begin
                    n_state = S_SHIFT;
                end else if (pos_p1 < count_x) begin
                    n_pos = r_pos + 1'b1;
                end else begin
                    n_res_st = ST_NOTFOUND;
                    fin      = 1'b1;
                end
            end
            S_SHIFT: begin
                // move entry r_pos+1 (now on the read port) down to r_pos
                if (pos_p1 < count_x) begin
                    ram_we    = 1'b1;
                    ram_re    = (pos_p2 < count_x);
                    ram_raddr = wrap_addr(r_head, pos_p2);
                    n_pos     = r_pos + 1'b1;
                end else begin
                    n_count  = r_count - 1'b1;
                    n_res_st = ST_OK;
                    fin      = 1'b1;
                end
            end
            S_RESP: begin
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        out_load = fin && out_free;
        if (fin) begin
            n_state = out_free ? S_IDLE : S_RESP;
        end
    end

    assign count_ext = {{CNT_W{1'b0}}, n_count};

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        n_out_val   = r_out_val;
        n_out_st    = r_out_st;
        n_out_cnt   = r_out_cnt;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_val   = n_res_val;
            n_out_st    = n_res_st;
            n_out_cnt   = count_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_out_val <= n_out_val;
        r_out_st  <= n_out_st;
        r_out_cnt <= n_out_cnt;
    end

    `DQRM_ASSERT_NEXT(a_full_keeps_count, i_clk, i_rst_n, out_load && (n_res_st == ST_FULL), r_count == DEPTH_CNT, "refused enqueue while not full")
    `DQRM_ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n, (r_state == S_IDLE) && i_valid && (i_cmd == CMD_ENQ) && (r_count != DEPTH_CNT), r_count == $past(r_count) + 1'b1, "enqueue did not grow count")
    `DQRM_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "shift reads the entry it writes")
    `DQRM_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN) || (r_state == S_SHIFT), r_pos < r_count, "scan position past tail")

endmodule

`default_nettype wire

[tb/deque_result_checker.sv]
// Checker for the deque: predicts each result from the accepted commands and compares
`timescale 1ns / 1ps

module deque_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [dqrm_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [dqrm_pkg::VAL_W-1:0] i_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [dqrm_pkg::VAL_W-1:0] i_result_value,
    input  logic [dqrm_pkg::ST_W-1:0]         i_status,
    input  logic [dqrm_pkg::CNT_W-1:0]        i_entry_count,
    output int                                o_err_count,
    output int                                o_pending
);

    import dqrm_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
        logic [CNT_W-1:0]        count;
    } t_deque_result;

    logic signed [VAL_W-1:0] stored_words[$];
    t_deque_result           expected_results[$];
    int                      mismatches = 0;

    // Apply one command to the shadow store and return what the block must answer.
    function automatic t_deque_result apply_command(t_cmd cmd, logic signed [VAL_W-1:0] val);
        t_deque_result r;
        int            hit;
        int            n;
        r.value  = val;
        r.status = ST_OK;
        hit      = -1;
        case (cmd)
            CMD_ENQ: begin
                if (stored_words.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                    stored_words.push_back(val);
            end
            CMD_DEQ: begin
                if (stored_words.size() == 0) begin
                    r.value  = '0;
                    r.status = ST_EMPTY;
                end else begin
                    r.value = stored_words.pop_front();
                end
            end
            CMD_REM: begin
                // first match from the head; later words close the gap
                foreach (stored_words[k])
                    if (hit < 0 && stored_words[k] == val)
                        hit = k;
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                    stored_words.delete(hit);
            end
            CMD_POP: begin
                if (stored_words.size() == 0) begin
                    r.value  = '0;
                    r.status = ST_EMPTY;
                end else begin
                    r.value = stored_words.pop_back();
                end
            end
        endcase
        n       = stored_words.size();
        r.count = n[CNT_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(string what, t_deque_result want, t_deque_result got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected value %0d status %s count %0d,",
                      " got value %0d status %s count %0d"},
                     $realtime, what, want.value, want.status.name(), want.count,
                     got.value, got.status.name(), got.count);
    endtask

    always @(posedge i_clk) begin
        t_deque_result got;
        t_deque_result want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                got.value  = i_result_value;
                got.status = t_status'(i_status);
                got.count  = i_entry_count;
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result", got, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value || got.status !== want.status
                            || got.count !== want.count)
                        note_mismatch("result mismatch", want, got);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_command(t_cmd'(i_cmd), i_value));
        end
        o_err_count <= mismatches;
        o_pending   <= expected_results.size();
    end

endmodule

[tb/tb.sv]
// Top of the deque testbench: clock, reset, command stimulus, stall pattern and verdict
`timescale 1ns / 1ps

module tb;
    import dqrm_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 700;
    localparam int POOL_SIZE    = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} t_mix;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [CMD_W-1:0]        i_cmd   = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [VAL_W-1:0] o_result_value;
    logic [ST_W-1:0]         o_status;
    logic [CNT_W-1:0]        o_entry_count;

    int                      err_count;
    int                      pending;
    int                      cycle_count = 0;
    int                      burst_left  = 0;
    int                      stall_left  = 0;
    t_rx_mode                stall_mode  = RX_OPEN;
    logic signed [VAL_W-1:0] value_pool[POOL_SIZE];

    deque_with_remove_by_value #(.DEPTH(DEPTH)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    deque_result_checker #(.DEPTH(DEPTH)) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_result_value (o_result_value),
        .i_status       (o_status),
        .i_entry_count  (o_entry_count),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: switch at random between stall patterns: open, light, heavy and periodic.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_rx_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            RX_OPEN:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:  i_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    // Present one word and hold it until accepted; idle between bursts.
    task automatic send_word(input t_cmd cmd, input logic signed [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Favor a small pool so removes find matches and duplicates occur.
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    function automatic t_cmd pick_command(t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                return t_cmd'(roll < 70 ? CMD_ENQ : roll < 80 ? CMD_DEQ :
                              roll < 90 ? CMD_POP : CMD_REM);
            MIX_EVEN:
                return t_cmd'(roll < 25 ? CMD_ENQ : roll < 50 ? CMD_DEQ :
                              roll < 75 ? CMD_POP : CMD_REM);
            default:
                return t_cmd'(roll < 15 ? CMD_ENQ : roll < 40 ? CMD_DEQ :
                              roll < 65 ? CMD_POP : CMD_REM);
        endcase
    endfunction

    initial begin
        int   sent;
        int   seg_len;
        t_mix mix;
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int k = 4; k < POOL_SIZE; k++)
            value_pool[k] = $urandom();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store: every command that takes or searches must be refused
        send_word(CMD_DEQ, 32'sd7);
        send_word(CMD_POP, -32'sd7);
        send_word(CMD_REM, '0);
        send_word(CMD_ENQ, 32'sh7FFF_FFFF);
        send_word(CMD_ENQ, 32'sh8000_0000);
        send_word(CMD_ENQ, '0);
        send_word(CMD_ENQ, -32'sd1);
        send_word(CMD_ENQ, 32'sh8000_0000);
        send_word(CMD_ENQ, 32'sd5);
        send_word(CMD_REM, 32'sh8000_0000);   // duplicate: first one from the head goes
        send_word(CMD_REM, 32'sd12345);
        send_word(CMD_REM, 32'sd5);           // match at the tail
        send_word(CMD_REM, 32'sh7FFF_FFFF);   // match at the head
        send_word(CMD_DEQ, '0);
        send_word(CMD_POP, '0);
        send_word(CMD_POP, '0);               // last word by pop
        send_word(CMD_POP, '0);
        send_word(CMD_ENQ, 32'sh5555_5555);
        send_word(CMD_DEQ, '0);               // last word by dequeue
        send_word(CMD_DEQ, '0);
        send_word(CMD_ENQ, 32'shAAAA_AAAA);
        send_word(CMD_REM, 32'shAAAA_AAAA);   // remove the only word
        send_word(CMD_REM, 32'shAAAA_AAAA);

        // random segments that lean toward filling, balance or draining
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            mix     = t_mix'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 60);
            if ($urandom_range(0, 3) == 0)
                value_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom();
            for (int k = 0; k < seg_len && sent < RANDOM_WORDS; k++) begin
                send_word(pick_command(mix), pick_value());
                sent++;
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
